// File: rtl/hgtw_pkg.sv
// Shared types, constants and arithmetic helpers for the hex grid wrap core.
package hgtw_pkg;

   // Field widths.
   localparam int KEY_W    = 16;
   localparam int RAD_W    = 10;
   localparam int MIR_W    = 3;

   // Wrap limits.
   localparam int MAX_STEPS    = 16;
   localparam int MIRROR_COUNT = 6;
   localparam int STEP_W       = $clog2(MAX_STEPS + 1);

   // Internal coordinate width: a key plus MAX_STEPS subtractions of the largest
   // center component (2R+1 at the largest radius), with a sign bit.
   localparam int MAX_RADIUS = (1 << RAD_W) - 1;
   localparam int COORD_W =
      $clog2((1 << (KEY_W - 1)) + MAX_STEPS * (2 * MAX_RADIUS + 1) + 1) + 1;
   // Hex length width: sum of three magnitudes one bit wider than a coordinate.
   localparam int LEN_W = COORD_W + 3;

   // Mirror index codes.
   localparam logic [MIR_W-1:0] MIRROR_0 = 3'd0;
   localparam logic [MIR_W-1:0] MIRROR_1 = 3'd1;
   localparam logic [MIR_W-1:0] MIRROR_2 = 3'd2;
   localparam logic [MIR_W-1:0] MIRROR_3 = 3'd3;
   localparam logic [MIR_W-1:0] MIRROR_4 = 3'd4;
   localparam logic [MIR_W-1:0] MIRROR_5 = 3'd5;

   // Request and response payloads.
   typedef struct packed {
      logic signed [KEY_W-1:0] key_q;
      logic signed [KEY_W-1:0] key_r;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] wrapped_q;
      logic signed [KEY_W-1:0] wrapped_r;
      logic                    already_inside;
      logic [MIR_W-1:0]        mirror_used;
      logic                    wrap_failed;
   } rsp_type;

   // Axial coordinate at internal width.
   typedef struct packed {
      logic signed [COORD_W-1:0] q;
      logic signed [COORD_W-1:0] r;
   } coord_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIST,
      ST_PICK,
      ST_SUB
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_key;
      logic load_dist;
      logic load_best;
      logic sub_step;
      logic load_rsp;
      logic rsp_inside;
      logic rsp_failed;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_bounds;
      logic steps_zero;
      logic steps_max;
   } stat_type;

   // Hex distance from the origin: (|q| + |r| + |q+r|) / 2.
   function automatic logic [LEN_W-1:0] hex_len(input logic signed [COORD_W-1:0] q,
                                                input logic signed [COORD_W-1:0] r);
      logic signed [COORD_W:0] qe;
      logic signed [COORD_W:0] re;
      logic signed [COORD_W:0] se;
      logic [COORD_W:0]        aq;
      logic [COORD_W:0]        ar;
      logic [COORD_W:0]        as_v;
      logic [LEN_W-1:0]        sum;
      qe   = (COORD_W + 1)'(q);
      re   = (COORD_W + 1)'(r);
      se   = qe + re;
      aq   = (qe < 0) ? -qe : qe;
      ar   = (re < 0) ? -re : re;
      as_v = (se < 0) ? -se : se;
      sum  = LEN_W'(aq) + LEN_W'(ar) + LEN_W'(as_v);
      return sum >> 1;
   endfunction

   // Mirror center k: (2R+1, -R) rotated k times by (q,r) -> (-r, q+r).
   function automatic coord_type mirror_center(input logic [MIR_W-1:0] k,
                                               input logic [RAD_W-1:0] rad);
      logic signed [COORD_W-1:0] rs;
      logic signed [COORD_W-1:0] rp1;
      logic signed [COORD_W-1:0] tr;
      coord_type                 c;
      rs  = signed'({{(COORD_W - RAD_W){1'b0}}, rad});
      rp1 = rs + COORD_W'(1);
      tr  = rs + rp1;
      unique case (k)
         MIRROR_0: begin c.q = tr;   c.r = -rs;  end
         MIRROR_1: begin c.q = rs;   c.r = rp1;  end
         MIRROR_2: begin c.q = -rp1; c.r = tr;   end
         MIRROR_3: begin c.q = -tr;  c.r = rs;   end
         MIRROR_4: begin c.q = -rs;  c.r = -rp1; end
         MIRROR_5: begin c.q = rp1;  c.r = -tr;  end
         default:  begin c.q = tr;   c.r = -rs;  end
      endcase
      return c;
   endfunction

endpackage

// File: rtl/hgtw_dp.sv
// Datapath: radius register, working coordinate, mirror distances and result register.
module hgtw_dp import hgtw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [RAD_W-1:0] csr_data,
   input  req_type          req_data,
   input  cmd_type          cmd,
   output stat_type         stat,
   output rsp_type          rsp_data
);

   logic [RAD_W-1:0]          radius_ff;
   coord_type                 key_ff;
   coord_type                 pos_ff, pos_in;
   logic [LEN_W-1:0]          dist_ff [MIRROR_COUNT];
   logic [MIR_W-1:0]          best_ff, best_in;
   logic [STEP_W-1:0]         steps_ff, steps_in;
   rsp_type                   rsp_ff, rsp_in;
   coord_type                 center [MIRROR_COUNT];
   logic [LEN_W-1:0]          dist_in [MIRROR_COUNT];
   logic [LEN_W-1:0]          pos_len;
   logic [LEN_W-1:0]          pick_d;
   logic [MIR_W-1:0]          pick_k;
   logic signed [COORD_W-1:0] dq;
   logic signed [COORD_W-1:0] dr;

   // Radius register; the port always takes a write.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_valid) begin
         radius_ff <= csr_data;
      end
   end

   // The six mirror centers follow from the radius.
   always_comb begin
      for (int k = 0; k < MIRROR_COUNT; k++) begin
         center[k] = mirror_center(MIR_W'(k), radius_ff);
      end
   end

   // Bounds check of the working coordinate.
   assign pos_len         = hex_len(pos_ff.q, pos_ff.r);
   assign stat.in_bounds  = (pos_len <= LEN_W'(radius_ff));
   assign stat.steps_zero = (steps_ff == '0);
   assign stat.steps_max  = (steps_ff == STEP_W'(MAX_STEPS));

   // Distance from the key to each mirror center.
   always_comb begin
      for (int k = 0; k < MIRROR_COUNT; k++) begin
         dq         = key_ff.q - center[k].q;
         dr         = key_ff.r - center[k].r;
         dist_in[k] = hex_len(dq, dr);
      end
   end

   // Closest center; a strict compare keeps the lowest index on a tie.
   always_comb begin
      pick_d = dist_ff[0];
      pick_k = MIRROR_0;
      for (int k = 1; k < MIRROR_COUNT; k++) begin
         if (dist_ff[k] < pick_d) begin
            pick_d = dist_ff[k];
            pick_k = MIR_W'(k);
         end
      end
   end

   // Working coordinate, chosen mirror and step count.
   always_comb begin
      pos_in   = pos_ff;
      best_in  = best_ff;
      steps_in = steps_ff;
      if (cmd.load_key) begin
         pos_in.q = COORD_W'(req_data.key_q);
         pos_in.r = COORD_W'(req_data.key_r);
         best_in  = MIRROR_0;
         steps_in = '0;
      end else if (cmd.sub_step) begin
         pos_in.q = pos_ff.q - center[best_ff].q;
         pos_in.r = pos_ff.r - center[best_ff].r;
         steps_in = steps_ff + STEP_W'(1);
      end else if (cmd.load_best) begin
         best_in = pick_k;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      best_ff  <= best_in;
      steps_ff <= steps_in;
      if (cmd.load_key) begin
         key_ff <= pos_in;
      end
      if (cmd.load_dist) begin
         for (int k = 0; k < MIRROR_COUNT; k++) begin
            dist_ff[k] <= dist_in[k];
         end
      end
   end

   // Result register, loaded when the controller finishes a request.
   always_comb begin
      rsp_in                = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.wrapped_q      = pos_ff.q[KEY_W-1:0];
         rsp_in.wrapped_r      = pos_ff.r[KEY_W-1:0];
         rsp_in.already_inside = cmd.rsp_inside;
         rsp_in.mirror_used    = best_ff;
         rsp_in.wrap_failed    = cmd.rsp_failed;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/hgtw_ctrl.sv
// Controller: request sequencing, step loop and result handshake.
module hgtw_ctrl import hgtw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      out_vld_ff, out_vld_in;
   logic      out_free;

   // The result register can take a new result when empty or being drained.
   assign out_free = !out_vld_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_key = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (stat.steps_zero) begin
               // First check: an in-bounds key passes unchanged.
               if (stat.in_bounds) begin
                  if (out_free) begin
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_inside = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end else begin
                  state_in = ST_DIST;
               end
            end else if (stat.in_bounds || stat.steps_max) begin
               if (out_free) begin
                  cmd.load_rsp   = 1'b1;
                  cmd.rsp_failed = !stat.in_bounds;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.sub_step = 1'b1;
            end
         end
         ST_DIST: begin
            cmd.load_dist = 1'b1;
            state_in      = ST_PICK;
         end
         ST_PICK: begin
            cmd.load_best = 1'b1;
            state_in      = ST_SUB;
         end
         ST_SUB: begin
            // The first subtraction is unconditional.
            cmd.sub_step = 1'b1;
            state_in     = ST_EVAL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      if (cmd.load_rsp) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   assign rsp_valid = out_vld_ff;

`ifndef NO_ASSERTIONS
   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> out_free)
      else $error("result loaded while output register busy");

   // An accepted request always moves on to the bounds check.
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL))
      else $error("accepted request did not reach bounds check");

   // The step loop never subtracts past the step limit.
   a_step_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.sub_step |-> !stat.steps_max)
      else $error("subtraction beyond the step limit");
`endif

endmodule

// File: rtl/hex_grid_torus_wrap_core.sv
// Top level of the hex grid wrap core: controller and datapath.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_type  (key_q, key_r)
//   rsp_      out        rsp_valid/rsp_ready   rsp_type  (wrapped_q .. wrap_failed)
//   csr_      in         csr_valid/csr_ready   outer_radius, 10 bits
//
// An in-bounds key goes from acceptance to the check and, once the result register is free, into it.
// An out-of-bounds key with n subtractions (n <= MAX_STEPS) passes in order through the check,
// the six distances, the pick and the first step, then steps until in bounds or at MAX_STEPS.
// The step loop sets the latency; only the idle state takes a request.
// The result register lets the next request in while a result waits; reset is synchronous.
module hex_grid_torus_wrap_core import hgtw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [RAD_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // The radius register takes a write in any cycle.
   assign csr_ready = 1'b1;

   hgtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hgtw_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule
